// File: hw/rtl/pidf_pkg.sv
// shared types, register codes and port sizing for the filtered pid controller
package pidf_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int GAIN_W          = 28;

  // control law codes (code 3 runs the filtered positional law)
  localparam logic [1:0] LAW_PLAIN = 2'd0;
  localparam logic [1:0] LAW_INCR  = 2'd2;

  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    REG_LAW_MODE,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_OUTPUT_LIMIT,
    REG_INTEG_TERM_LIMIT,
    REG_ERROR_SUM_LIMIT
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_EXEC,
    PH_LOAD,
    PH_LO,
    PH_HI,
    PH_RND
  } phase_t;

  typedef enum logic [4:0] {
    ST_START,
    ST_MEAS_A,
    ST_MEAS_B,
    ST_ERR_RAW,
    ST_ERR_A,
    ST_ERR_B,
    ST_ACC,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_DF_A,
    ST_DF_B,
    ST_CLAMP,
    ST_SUM_P,
    ST_SUM_I,
    ST_SUM_D,
    ST_OUT_A,
    ST_OUT_B,
    ST_FINAL
  } step_t;

  function automatic int cfg_data_w(input int vw);
    return (vw - 1 > 32) ? 64 : 32;
  endfunction

  function automatic int cfg_addr_w(input int vw);
    return (vw - 1 > 32) ? 6 : 5;
  endfunction

endpackage

// File: hw/rtl/pid_controller_filtered.sv
// fixed-point pid controller with plain, filtered and incremental laws on one shared multiplier
//
// Input channel (in_valid/in_stall) carries opcode, measured_value and target_value; output
// channel (out_valid/out_stall) returns drive_value with the two clamp flags, one result per
// input transfer. Gains, limits and the law are written over the APB port; the user must
// write them only while idle, as the block does not enforce it. A read returns the stored value.
// One control step runs as a microsequence on a single multiplier that handles the operand
// in two halves: each product passes through operand load, low half, high half, and round
// and saturate, and each add/saturate step runs as a step of its own without the multiplier.
// in_stall stays high from the input transfer until the result is loaded into the output
// register, so a new item is taken only after the previous result has been loaded there.
// The output register holds a result while out_stall is high; a following item may run
// meanwhile and waits in its last step until that register is free.
// Synchronous reset sets law_mode to filtered positional, all gains and limits to zero, and
// clears the controller history and the output valid.
module pid_controller_filtered
  import pidf_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   opcode,
  input  logic signed [VALUE_WIDTH-1:0]          measured_value,
  input  logic signed [VALUE_WIDTH-1:0]          target_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [VALUE_WIDTH-1:0]          drive_value,
  output logic                                   output_clamped,
  output logic                                   integral_clamped,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cfg_addr_w(VALUE_WIDTH)-1:0]     paddr,
  input  logic [cfg_data_w(VALUE_WIDTH)-1:0]     pwdata,
  output logic [cfg_data_w(VALUE_WIDTH)-1:0]     prdata,
  output logic                                   pready
);

  localparam int VW    = VALUE_WIDTH;
  localparam int OW    = VW + 3;          // widest signed operand (second difference)
  localparam int MW    = VW + 2;          // operand magnitude
  localparam int LO_W  = (MW + 1) / 2;
  localparam int PW    = MW + GAIN_W;     // exact product
  localparam int RW    = PW + 1;
  localparam int QW    = PW + 1 - FRAC_BITS;
  localparam int LW    = VW - 1;
  localparam int DW    = cfg_data_w(VALUE_WIDTH);
  localparam int AW    = cfg_addr_w(VALUE_WIDTH);

  localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
  localparam longint unsigned C95_L = (95 * ONE_L + 50) / 100;
  localparam longint unsigned C85_L = (85 * ONE_L + 50) / 100;
  localparam logic [GAIN_W-1:0] C95  = GAIN_W'(C95_L);
  localparam logic [GAIN_W-1:0] C95C = GAIN_W'(ONE_L - C95_L);
  localparam logic [GAIN_W-1:0] C85  = GAIN_W'(C85_L);
  localparam logic [GAIN_W-1:0] C85C = GAIN_W'(ONE_L - C85_L);

  localparam logic [RW-1:0] HALF_Q  = RW'(ONE_L >> 1);
  localparam logic [QW-1:0] CAP_POS = {{(QW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic [QW-1:0] CAP_NEG = CAP_POS + QW'(1);
  localparam logic signed [OW-1:0] VMAX_O = {4'b0000, {(VW-1){1'b1}}};
  localparam logic signed [OW-1:0] VMIN_O = {4'b1111, {(VW-1){1'b0}}};

  function automatic logic signed [OW-1:0] ext(input logic signed [VW-1:0] x);
    return {{(OW-VW){x[VW-1]}}, x};
  endfunction

  function automatic logic signed [VW-1:0] sat_v(input logic signed [OW-1:0] x);
    if (x > VMAX_O) return VMAX_O[VW-1:0];
    if (x < VMIN_O) return VMIN_O[VW-1:0];
    return x[VW-1:0];
  endfunction

  // {hit, value}
  function automatic logic [VW:0] clamp_sym(input logic signed [VW-1:0] x,
                                            input logic [LW-1:0] lim);
    logic signed [VW:0] xe;
    logic signed [VW:0] lp;
    logic signed [VW:0] ln;
    xe = {x[VW-1], x};
    lp = {2'b00, lim};
    ln = -lp;
    if (xe > lp) return {1'b1, lp[VW-1:0]};
    if (xe < ln) return {1'b1, ln[VW-1:0]};
    return {1'b0, x};
  endfunction

  // configuration
  logic [1:0]        law_mode;
  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] integ_gain;
  logic [GAIN_W-1:0] deriv_gain;
  logic [LW-1:0]     output_limit;
  logic [LW-1:0]     integ_term_limit;
  logic [LW-1:0]     error_sum_limit;

  // controller history
  logic signed [VW-1:0] filtered_measure;
  logic signed [VW-1:0] error_now;
  logic signed [VW-1:0] error_prev;
  logic signed [VW-1:0] error_prev2;
  logic signed [VW-1:0] error_accum;
  logic signed [VW-1:0] prev_deriv_term;
  logic signed [VW-1:0] prev_output;

  // working registers
  logic                 op_reg;
  logic signed [VW-1:0] meas;
  logic signed [VW-1:0] targ;
  logic signed [VW-1:0] t0;
  logic signed [VW-1:0] t1;
  logic signed [VW-1:0] p_term;
  logic signed [VW-1:0] i_term;
  logic signed [VW-1:0] d_term;
  logic signed [OW-1:0] sum;
  logic                 ihit;

  // shared multiplier
  logic                    mneg;
  logic [MW-1:0]           mmag;
  logic [GAIN_W-1:0]       mgain;
  logic [PW-1:0]           acc;
  logic [LO_W-1:0]         mpart;
  logic [LO_W+GAIN_W-1:0]  prod;
  logic signed [OW-1:0]    opnd;
  logic [OW-1:0]           opnd_mag;
  logic [GAIN_W-1:0]       gain_sel;
  logic [RW-1:0]           rsum;
  logic [QW-1:0]           qv;
  logic [QW-1:0]           cap;
  logic [QW-1:0]           rmag;
  logic [VW-1:0]           rv;
  logic signed [VW-1:0]    rres;

  // sequencer
  phase_t phase;
  phase_t phase_next;
  step_t  step;
  step_t  step_next;
  step_t  succ;
  logic   in_xfer;
  logic   out_xfer;
  logic   fire_final;
  logic   is_plain;
  logic   is_incr;
  logic   succ_mul;
  logic   blend_b;

  logic [VW:0] ci;
  logic [VW:0] ca;
  logic [VW:0] fo;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[AW-1:AW-3]);
  assign is_plain = (law_mode == LAW_PLAIN);
  assign is_incr  = (law_mode == LAW_INCR);
  assign out_xfer = out_valid & ~out_stall;

  always_comb begin
    unique case (cfg_idx)
      REG_LAW_MODE:         prdata = DW'(law_mode);
      REG_PROP_GAIN:        prdata = DW'(prop_gain);
      REG_INTEG_GAIN:       prdata = DW'(integ_gain);
      REG_DERIV_GAIN:       prdata = DW'(deriv_gain);
      REG_OUTPUT_LIMIT:     prdata = DW'(output_limit);
      REG_INTEG_TERM_LIMIT: prdata = DW'(integ_term_limit);
      REG_ERROR_SUM_LIMIT:  prdata = DW'(error_sum_limit);
      default:              prdata = '0;
    endcase
  end

  // sequencer: next step, next phase, handshake
  always_comb begin
    unique case (step)
      ST_START:   succ = (op_reg == OP_CLEAR) ? ST_FINAL : (is_plain ? ST_ERR_RAW : ST_MEAS_A);
      ST_MEAS_A:  succ = ST_MEAS_B;
      ST_MEAS_B:  succ = ST_ERR_RAW;
      ST_ERR_RAW: succ = is_plain ? ST_ACC : ST_ERR_A;
      ST_ERR_A:   succ = ST_ERR_B;
      ST_ERR_B:   succ = ST_ACC;
      ST_ACC:     succ = ST_PROP;
      ST_PROP:    succ = ST_INTEG;
      ST_INTEG:   succ = ST_DERIV;
      ST_DERIV:   succ = is_plain ? ST_CLAMP : ST_DF_A;
      ST_DF_A:    succ = ST_DF_B;
      ST_DF_B:    succ = ST_CLAMP;
      ST_CLAMP:   succ = ST_SUM_P;
      ST_SUM_P:   succ = ST_SUM_I;
      ST_SUM_I:   succ = ST_SUM_D;
      ST_SUM_D:   succ = is_plain ? ST_FINAL : ST_OUT_A;
      ST_OUT_A:   succ = ST_OUT_B;
      ST_OUT_B:   succ = ST_FINAL;
      default:    succ = ST_START;
    endcase

    succ_mul = (succ == ST_MEAS_A) || (succ == ST_MEAS_B) || (succ == ST_ERR_A) ||
               (succ == ST_ERR_B) || (succ == ST_PROP) || (succ == ST_INTEG) ||
               (succ == ST_DERIV) || (succ == ST_DF_A) || (succ == ST_DF_B) ||
               (succ == ST_OUT_A) || (succ == ST_OUT_B);
    blend_b  = (step == ST_MEAS_B) || (step == ST_ERR_B) || (step == ST_DF_B) ||
               (step == ST_OUT_B);

    in_stall   = (phase != PH_IDLE);
    in_xfer    = in_valid & ~in_stall;
    fire_final = (phase == PH_EXEC) && (step == ST_FINAL) && (~out_valid | ~out_stall);

    phase_next = phase;
    step_next  = step;
    unique case (phase)
      PH_IDLE: begin
        if (in_xfer) begin
          phase_next = PH_EXEC;
          step_next  = ST_START;
        end
      end
      PH_EXEC: begin
        if (step == ST_FINAL) begin
          if (fire_final) phase_next = PH_IDLE;
        end else begin
          step_next  = succ;
          phase_next = succ_mul ? PH_LOAD : PH_EXEC;
        end
      end
      PH_LOAD: phase_next = PH_LO;
      PH_LO:   phase_next = PH_HI;
      PH_HI:   phase_next = PH_RND;
      PH_RND: begin
        if (blend_b) begin
          phase_next = PH_EXEC;
        end else begin
          step_next  = succ;
          phase_next = succ_mul ? PH_LOAD : PH_EXEC;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= ST_START;
    end else begin
      phase <= phase_next;
      step  <= step_next;
    end
  end

  // operand and coefficient for the next product
  always_comb begin
    unique case (step)
      ST_MEAS_A: opnd = ext(meas);
      ST_MEAS_B: opnd = ext(filtered_measure);
      ST_ERR_A:  opnd = ext(error_now);
      ST_ERR_B:  opnd = ext(error_prev);
      ST_PROP:   opnd = is_incr ? ext(error_now) - ext(error_prev) : ext(error_now);
      ST_INTEG:  opnd = is_incr ? ext(error_now) : ext(error_accum);
      ST_DERIV:  opnd = is_incr ? ext(error_now) - (ext(error_prev) <<< 1) + ext(error_prev2)
                                : ext(error_now) - ext(error_prev);
      ST_DF_A:   opnd = ext(d_term);
      ST_DF_B:   opnd = ext(prev_deriv_term);
      ST_OUT_A:  opnd = sum;
      ST_OUT_B:  opnd = ext(prev_output);
      default:   opnd = '0;
    endcase

    unique case (step)
      ST_MEAS_A:                     gain_sel = C95;
      ST_MEAS_B:                     gain_sel = C95C;
      ST_ERR_A, ST_DF_A, ST_OUT_A:   gain_sel = C85;
      ST_ERR_B, ST_DF_B, ST_OUT_B:   gain_sel = C85C;
      ST_PROP:                       gain_sel = prop_gain;
      ST_INTEG:                      gain_sel = integ_gain;
      ST_DERIV:                      gain_sel = deriv_gain;
      default:                       gain_sel = '0;
    endcase
  end

  assign opnd_mag = opnd[OW-1] ? (~opnd + OW'(1)) : opnd;

  // one multiplier, low half then high half of the magnitude
  assign mpart = (phase == PH_LO) ? mmag[LO_W-1:0] : LO_W'(mmag[MW-1:LO_W]);
  assign prod  = mpart * mgain;

  // round half away from zero on the magnitude, then saturate and restore the sign
  assign rsum = {1'b0, acc} + HALF_Q;
  assign qv   = rsum[PW:FRAC_BITS];
  assign cap  = mneg ? CAP_NEG : CAP_POS;
  assign rmag = (qv > cap) ? cap : qv;
  assign rv   = rmag[VW-1:0];
  assign rres = mneg ? (~rv + VW'(1)) : rv;

  assign ci = clamp_sym(i_term, integ_term_limit);
  assign ca = clamp_sym(error_accum, error_sum_limit);
  assign fo = clamp_sym(sum[VW-1:0], output_limit);

  // configuration, history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      law_mode         <= 2'd1;
      prop_gain        <= '0;
      integ_gain       <= '0;
      deriv_gain       <= '0;
      output_limit     <= '0;
      integ_term_limit <= '0;
      error_sum_limit  <= '0;
      filtered_measure <= '0;
      error_now        <= '0;
      error_prev       <= '0;
      error_prev2      <= '0;
      error_accum      <= '0;
      prev_deriv_term  <= '0;
      prev_output      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_LAW_MODE:         law_mode         <= pwdata[1:0];
          REG_PROP_GAIN:        prop_gain        <= pwdata[GAIN_W-1:0];
          REG_INTEG_GAIN:       integ_gain       <= pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN:       deriv_gain       <= pwdata[GAIN_W-1:0];
          REG_OUTPUT_LIMIT:     output_limit     <= pwdata[LW-1:0];
          REG_INTEG_TERM_LIMIT: integ_term_limit <= pwdata[LW-1:0];
          REG_ERROR_SUM_LIMIT:  error_sum_limit  <= pwdata[LW-1:0];
          default: ;
        endcase
      end

      if (fire_final) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end

      if (phase == PH_EXEC) begin
        unique case (step)
          ST_START: begin
            if (op_reg == OP_CLEAR) begin
              filtered_measure <= '0;
              error_now        <= '0;
              error_prev       <= '0;
              error_prev2      <= '0;
              error_accum      <= '0;
              prev_deriv_term  <= '0;
              prev_output      <= '0;
            end else begin
              error_prev <= error_now;
              // the plain law keeps the older error and takes the raw measurement
              if (is_plain) filtered_measure <= meas;
              else          error_prev2      <= error_prev;
            end
          end
          ST_MEAS_B:  filtered_measure <= sat_v(ext(t0) + ext(t1));
          ST_ERR_RAW: error_now        <= sat_v(ext(targ) - ext(filtered_measure));
          ST_ERR_B:   error_now        <= sat_v(ext(t0) + ext(t1));
          ST_ACC:     error_accum      <= sat_v(ext(error_accum) + ext(error_now));
          ST_DF_B:    prev_deriv_term  <= sat_v(ext(t0) + ext(t1));
          ST_CLAMP: begin
            error_accum <= ca[VW-1:0];
            if (is_plain) prev_deriv_term <= d_term;
          end
          ST_FINAL: begin
            if (fire_final) prev_output <= fo[VW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // working registers, multiplier and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_reg <= opcode;
      meas   <= measured_value;
      targ   <= target_value;
    end

    unique case (phase)
      PH_LOAD: begin
        mneg  <= opnd[OW-1];
        mmag  <= opnd_mag[MW-1:0];
        mgain <= gain_sel;
      end
      PH_LO: acc <= PW'(prod);
      PH_HI: acc <= acc + (PW'(prod) << LO_W);
      PH_RND: begin
        unique case (step)
          ST_PROP:  p_term <= rres;
          ST_INTEG: i_term <= rres;
          ST_DERIV: d_term <= rres;
          ST_MEAS_B, ST_ERR_B, ST_DF_B, ST_OUT_B: t1 <= rres;
          default:  t0 <= rres;
        endcase
      end
      PH_EXEC: begin
        unique case (step)
          ST_START: begin
            sum  <= '0;
            ihit <= 1'b0;
          end
          ST_CLAMP: begin
            i_term <= ci[VW-1:0];
            ihit   <= ci[VW] | ca[VW];
          end
          ST_SUM_P: sum <= (is_incr ? ext(prev_output) : '0) + ext(p_term);
          ST_SUM_I: sum <= sum + ext(i_term);
          ST_SUM_D: sum <= ext(sat_v(sum + ext(prev_deriv_term)));
          ST_OUT_B: sum <= ext(sat_v(ext(t0) + ext(t1)));
          default: ;
        endcase
      end
      default: ;
    endcase

    if (fire_final) begin
      drive_value      <= fo[VW-1:0];
      output_clamped   <= fo[VW];
      integral_clamped <= ihit;
    end
  end

endmodule

// File: sim/pid_controller_filtered_tb.sv
// self-checking testbench for the filtered pid controller: directed laws, limits and random loops
module pid_controller_filtered_tb;
  import pidf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = DEF_VALUE_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int DW = cfg_data_w(DEF_VALUE_WIDTH);
  localparam int AW = cfg_addr_w(DEF_VALUE_WIDTH);

  localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint unsigned ONE_Q = 64'd1 << FB;
  localparam longint unsigned HALF_Q = 64'd1 << (FB - 1);
  localparam longint unsigned C95 = (95 * ONE_Q + 50) / 100;
  localparam longint unsigned C85 = (85 * ONE_Q + 50) / 100;
  localparam logic [31:0] GAIN_MASK = (32'd1 << GAIN_W) - 1;
  localparam logic [31:0] LIM_MASK = (32'd1 << (VW - 1)) - 1;
  localparam logic [31:0] LAW_MASK = 32'd3;

  localparam logic [1:0] LAW_FILT = 2'd1;
  localparam logic [1:0] LAW_SPARE = 2'd3;
  localparam logic OP_RUN = 1'b0;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [VW-1:0] drive;
    logic                 oc;
    logic                 ic;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic signed [VW-1:0] measured_value = '0;
  logic signed [VW-1:0] target_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] drive_value;
  logic output_clamped;
  logic integral_clamped;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  pid_controller_filtered u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .measured_value   (measured_value),
    .target_value     (target_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_value      (drive_value),
    .output_clamped   (output_clamped),
    .integral_clamped (integral_clamped),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // register shadow
  logic [1:0] cfg_law = LAW_FILT;
  longint unsigned kp = 0, ki = 0, kd = 0;
  longint unsigned lim_out = 0, lim_integ = 0, lim_sum = 0;

  // controller history
  longint fmeas = 0, e_now = 0, e_prev = 0, e_prev2 = 0;
  longint e_acc = 0, d_prev = 0, y_prev = 0;

  drive_t drive_due[$];
  int n_items = 0, n_clears = 0, n_results = 0, n_errors = 0, n_settings = 0;

  // sender pacing
  int gap_due = 0;
  int burst_left = 1;
  bit valid_low = 1'b1;

  function automatic longint sat_v(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // product shifted down by the fraction bits, magnitude rounded half up, saturated
  function automatic longint scale_q(longint a, longint unsigned g);
    longint unsigned m, cap, r;
    m = (a < 0) ? longint'(-a) : a;
    cap = (a < 0) ? longint'(VMAX) + 1 : longint'(VMAX);
    r = (m * g + HALF_Q) >> FB;
    if (r > cap) r = cap;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_sym(longint x, longint unsigned lim, inout bit hit);
    longint l;
    l = longint'(lim);
    if (x > l) begin
      hit = 1'b1;
      return l;
    end
    if (x < -l) begin
      hit = 1'b1;
      return -l;
    end
    return x;
  endfunction

  function automatic longint blend(longint a, longint b, longint unsigned c);
    return sat_v(scale_q(a, c) + scale_q(b, ONE_Q - c));
  endfunction

  function automatic drive_t control_step(logic op, longint meas, longint targ);
    drive_t res;
    longint p, i, d, sum, err, e1, e2, y_old, d_old;
    bit ihit, ohit;
    ihit = 1'b0;
    ohit = 1'b0;
    res = '0;
    if (op == OP_CLEAR) begin
      fmeas = 0; e_now = 0; e_prev = 0; e_prev2 = 0;
      e_acc = 0; d_prev = 0; y_prev = 0;
      return res;
    end
    if (cfg_law == LAW_PLAIN) begin
      // plain law keeps the second error history untouched
      e1 = e_now;
      e_prev = e1;
      fmeas = meas;
      err = sat_v(targ - meas);
      e_now = err;
      e_acc = sat_v(e_acc + err);
      p = scale_q(err, kp);
      i = scale_q(e_acc, ki);
      d = scale_q(err - e1, kd);
      i = clamp_sym(i, lim_integ, ihit);
      e_acc = clamp_sym(e_acc, lim_sum, ihit);
      d_prev = d;
      sum = sat_v(p + i + d);
    end else begin
      y_old = y_prev;
      d_old = d_prev;
      e_prev2 = e_prev;
      e_prev = e_now;
      e1 = e_prev;
      e2 = e_prev2;
      fmeas = blend(meas, fmeas, C95);
      err = sat_v(targ - fmeas);
      err = blend(err, e1, C85);
      e_now = err;
      e_acc = sat_v(e_acc + err);
      if (cfg_law == LAW_INCR) begin
        p = scale_q(err - e1, kp);
        i = scale_q(err, ki);
        d = scale_q(err - 2 * e1 + e2, kd);
      end else begin
        // integral uses the error sum before its clamp
        p = scale_q(err, kp);
        i = scale_q(e_acc, ki);
        d = scale_q(err - e1, kd);
      end
      d = blend(d, d_old, C85);
      d_prev = d;
      e_acc = clamp_sym(e_acc, lim_sum, ihit);
      i = clamp_sym(i, lim_integ, ihit);
      if (cfg_law == LAW_INCR) sum = sat_v(y_old + p + i + d);
      else sum = sat_v(p + i + d);
      sum = blend(sum, y_old, C85);
    end
    sum = clamp_sym(sum, lim_out, ohit);
    y_prev = sum;
    res.drive = sum[VW-1:0];
    res.oc = ohit;
    res.ic = ihit;
    return res;
  endfunction

  // signed value spread over +/- 2^(n-1)
  function automatic longint rand_span(int n);
    longint r;
    r = longint'($urandom) & ((longint'(1) <<< n) - 1);
    return r - (longint'(1) <<< (n - 1));
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return GAIN_MASK;
      2, 3: return $urandom_range(0, 1 << 17);
      4: return $urandom_range(0, 1 << 20);
      default: return $urandom & GAIN_MASK;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return LIM_MASK;
      2, 3: return $urandom_range(1 << 16, 1 << 26);
      4: return $urandom_range(1, 1 << 16);
      default: return $urandom & LIM_MASK;
    endcase
  endfunction

  // output side: the stall pattern switches among four kinds after each randomly drawn span
  int stall_kind = 0;
  int stall_span = 0;
  int stall_hold = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_span = $urandom_range(50, 400);
    end else begin
      stall_span = stall_span - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 7) < 5);
      default: begin
        // long holds so a following step waits on the output register
        if (stall_hold != 0) begin
          out_stall <= 1'b1;
          stall_hold = stall_hold - 1;
        end else begin
          out_stall <= 1'b0;
          stall_hold = $urandom_range(0, 150);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (drive_due.size() == 0) begin
        $display("%0t unexpected transfer on output: drive_value %0d", $time, drive_value);
        n_errors++;
      end else begin
        want = drive_due.pop_front();
        if (drive_value !== want.drive) begin
          $display("%0t drive_value mismatch: expected %0d, got %0d",
                   $time, want.drive, drive_value);
          n_errors++;
        end
        if (output_clamped !== want.oc) begin
          $display("%0t output_clamped mismatch: expected %0b, got %0b",
                   $time, want.oc, output_clamped);
          n_errors++;
        end
        if (integral_clamped !== want.ic) begin
          $display("%0t integral_clamped mismatch: expected %0b, got %0b",
                   $time, want.ic, integral_clamped);
          n_errors++;
        end
      end
    end
  end

  task automatic send_item(logic op, logic signed [VW-1:0] meas, logic signed [VW-1:0] targ);
    if (gap_due != 0) repeat (gap_due) @(posedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    measured_value <= meas;
    target_value <= targ;
    valid_low = 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    drive_due.push_back(control_step(op, longint'(meas), longint'(targ)));
    n_items++;
    if (op == OP_CLEAR) n_clears++;
    burst_left--;
    gap_due = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap_due = $urandom_range(1, 70);
        in_valid <= 1'b0;
        valid_low = 1'b1;
      end
    end
  endtask

  task automatic idle_inputs();
    if (!valid_low) begin
      in_valid <= 1'b0;
      valid_low = 1'b1;
    end
  endtask

  task automatic wait_drained();
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  // write every register, reading each back after its write
  task automatic program_regs(logic [31:0] law, logic [31:0] gp, logic [31:0] gi,
                              logic [31:0] gd, logic [31:0] lo, logic [31:0] li,
                              logic [31:0] ls);
    logic [31:0] vals [7];
    logic [31:0] masked;
    reg_idx_t idx;
    vals = '{law, gp, gi, gd, lo, li, ls};
    idle_inputs();
    wait_drained();
    for (int k = 0; k < 7; k++) begin
      idx = reg_idx_t'(k);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= AW'(4 * k);
      pwdata <= DW'(vals[k]);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx)
        REG_LAW_MODE: begin
          masked = vals[k] & LAW_MASK;
          cfg_law = masked[1:0];
        end
        REG_PROP_GAIN: begin
          masked = vals[k] & GAIN_MASK;
          kp = masked;
        end
        REG_INTEG_GAIN: begin
          masked = vals[k] & GAIN_MASK;
          ki = masked;
        end
        REG_DERIV_GAIN: begin
          masked = vals[k] & GAIN_MASK;
          kd = masked;
        end
        REG_OUTPUT_LIMIT: begin
          masked = vals[k] & LIM_MASK;
          lim_out = masked;
        end
        REG_INTEG_TERM_LIMIT: begin
          masked = vals[k] & LIM_MASK;
          lim_integ = masked;
        end
        default: begin
          masked = vals[k] & LIM_MASK;
          lim_sum = masked;
        end
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== DW'(masked)) begin
        $display("%0t register %s readback mismatch: expected %0h, got %0h",
                 $time, idx.name(), masked, prdata);
        n_errors++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // reset settings: filtered law, zero gains and limits
  task automatic test_reset_state();
    send_item(OP_RUN, VMIN, VMAX);
    send_item(OP_RUN, VMAX, VMIN);
    send_item(OP_CLEAR, VMAX, VMIN);
  endtask

  task automatic test_law_extremes();
    logic [1:0] laws [4];
    laws = '{LAW_PLAIN, LAW_FILT, LAW_INCR, LAW_SPARE};
    for (int k = 0; k < 4; k++) begin
      if (k[0]) program_regs(laws[k], GAIN_MASK, GAIN_MASK, 32'd0, LIM_MASK, LIM_MASK,
                             LIM_MASK);
      else program_regs(laws[k], 32'd1 << FB, 32'd1 << (FB - 2), GAIN_MASK, LIM_MASK,
                        32'd5 << FB, 32'd3 << FB);
      send_item(OP_RUN, VMIN, VMAX);
      send_item(OP_RUN, VMAX, VMIN);
      send_item(OP_RUN, '0, '0);
      send_item(OP_CLEAR, $urandom, $urandom);
    end
  endtask

  // zero limits force every clamped quantity to zero
  task automatic test_zero_limits();
    program_regs(LAW_FILT, 32'd1 << FB, 32'd1 << FB, 32'd1 << FB, 0, 0, 0);
    send_item(OP_RUN, -(32'sd5 <<< FB), 32'sd100 <<< FB);
    send_item(OP_RUN, -(32'sd5 <<< FB), 32'sd100 <<< FB);
    send_item(OP_RUN, '0, '0);
    send_item(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_operation(int phases, int per_phase);
    int sent, seq_len, span, noise_w;
    longint targ, meas;
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == 0)
        program_regs(LAW_FILT, GAIN_MASK, GAIN_MASK, GAIN_MASK, LIM_MASK, LIM_MASK, LIM_MASK);
      else
        program_regs($urandom_range(0, 3), pick_gain(), pick_gain(), pick_gain(),
                     pick_limit(), pick_limit(), pick_limit());
      sent = 0;
      while (sent < per_phase) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            // measurement settling toward a held setpoint
            seq_len = $urandom_range(5, 40);
            span = $urandom_range(4, 30);
            noise_w = $urandom_range(1, 16);
            targ = rand_span(span);
            meas = rand_span(span);
            for (int j = 0; j < seq_len && sent < per_phase; j++) begin
              meas = sat_v(meas + (targ - meas) / 4 + rand_span(noise_w));
              send_item(OP_RUN, meas[VW-1:0], targ[VW-1:0]);
              sent++;
            end
          end
          7, 8: begin
            for (int j = $urandom_range(1, 5); j > 0 && sent < per_phase; j--) begin
              send_item($urandom_range(0, 3) == 0, $urandom, $urandom);
              sent++;
            end
          end
          default: begin
            send_item(OP_CLEAR, $urandom, $urandom);
            sent++;
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_law_extremes();
    test_zero_limits();
    test_random_operation(10, 200);
    idle_inputs();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (drive_due.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, drive_due.size());
      n_errors++;
    end
    $display("run covered %0d input transfers (%0d clears) over %0d register settings",
             n_items, n_clears, n_settings);
    $display("%0d output transfers checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("pid_controller_filtered_tb: PASS");
    end else begin
      $display("pid_controller_filtered_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("%0t timeout", $time);
    $display("pid_controller_filtered_tb: FAIL");
    $finish;
  end

endmodule
